### hdl/blsp_pkg.sv
// ----------------------------------------------------------------------------
// blsp_pkg
// Shared types and codes for the Bresenham line stepper.
// ----------------------------------------------------------------------------
package blsp_pkg;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Classification of one word, as handed from front to back.
    typedef struct packed {
        logic op;
        logic x_negative;
        logic y_negative;
        logic x_is_major;
    } blsp_cmd_flags_t;

    localparam int FLAGS_BITS = $bits(blsp_cmd_flags_t);

endpackage

### hdl/bresenham_line_stepper_top.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper_top
// Integer Bresenham line rasterizer: load a line, then advance point by point.
//
//  Channel  Dir  tdata (low bit up)                      tuser / tlast
//  s_axis   in   start_x, start_y, end_x, end_y          tuser: operation
//  m_axis   out  point_x, point_y                        tlast: last_point
//
// One word per cycle sustained unless m_axis stalls; an advance passes through
// the front register, queue and output register. The step is one add, compare
// and subtract on the error counter per cycle, unless a stall holds it.
// Reset (rst_n, async low) empties the queue and leaves the stepper idle.
// A stall on m_axis backs up through the queue; the front keeps taking words
// until the queue is full.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_top
    import blsp_pkg::*;
#(
    parameter int COORD_BITS  = 11,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // start_x, start_y, end_x, end_y, zero fill
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // operation
    input  logic                                     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // point_x, point_y, zero fill
    output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata,
    output logic                                     m_axis_tlast
);

    localparam int DW      = COORD_BITS + 1;
    localparam int OUT_W   = ((2*COORD_BITS+7)/8)*8;
    localparam int CMD_W   = FLAGS_BITS + 2*COORD_BITS + 2*DW;

    logic                  f_valid;
    logic                  f_ready;
    blsp_cmd_flags_t       f_flags;
    logic [COORD_BITS-1:0] f_sx;
    logic [COORD_BITS-1:0] f_sy;
    logic [DW-1:0]         f_major;
    logic [DW-1:0]         f_minor;

    logic                  b_valid;
    logic                  b_ready;
    logic [CMD_W-1:0]      b_data;
    blsp_cmd_flags_t       b_flags;
    logic [COORD_BITS-1:0] b_sx;
    logic [COORD_BITS-1:0] b_sy;
    logic [DW-1:0]         b_major;
    logic [DW-1:0]         b_minor;

    logic [COORD_BITS-1:0] pt_x;
    logic [COORD_BITS-1:0] pt_y;

    blsp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tuser),
        .in_start_x  (s_axis_tdata[COORD_BITS-1:0]),
        .in_start_y  (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_end_x    (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .in_end_y    (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .cmd_valid   (f_valid),
        .cmd_ready   (f_ready),
        .cmd_flags   (f_flags),
        .cmd_start_x (f_sx),
        .cmd_start_y (f_sy),
        .cmd_major   (f_major),
        .cmd_minor   (f_minor)
    );

    blsp_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_flags, f_sx, f_sy, f_major, f_minor}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    assign {b_flags, b_sx, b_sy, b_major, b_minor} = b_data;

    blsp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (b_valid),
        .cmd_ready   (b_ready),
        .cmd_flags   (b_flags),
        .cmd_start_x (b_sx),
        .cmd_start_y (b_sy),
        .cmd_major   (b_major),
        .cmd_minor   (b_minor),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_x       (pt_x),
        .out_y       (pt_y),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({pt_y, pt_x});

endmodule

### hdl/blsp_front.sv
// ----------------------------------------------------------------------------
// blsp_front
// Accepts input words, works out step signs, absolute deltas and the major
// axis of a load, and holds the classified command in one register stage.
// ----------------------------------------------------------------------------
module blsp_front
    import blsp_pkg::*;
#(
    parameter int COORD_BITS = 11
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_op,
    input  logic signed [COORD_BITS-1:0]   in_start_x,
    input  logic signed [COORD_BITS-1:0]   in_start_y,
    input  logic signed [COORD_BITS-1:0]   in_end_x,
    input  logic signed [COORD_BITS-1:0]   in_end_y,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output blsp_cmd_flags_t                cmd_flags,
    output logic [COORD_BITS-1:0]          cmd_start_x,
    output logic [COORD_BITS-1:0]          cmd_start_y,
    output logic [COORD_BITS:0]            cmd_major,
    output logic [COORD_BITS:0]            cmd_minor
);

    localparam int DW = COORD_BITS + 1;

    logic                  valid_reg;
    blsp_cmd_flags_t       flags_reg;
    logic [COORD_BITS-1:0] sx_reg;
    logic [COORD_BITS-1:0] sy_reg;
    logic [DW-1:0]         major_reg;
    logic [DW-1:0]         minor_reg;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        ax;
    logic [DW-1:0]        ay;
    logic                 x_major;
    blsp_cmd_flags_t      flags_next;
    logic                 take;

    assign dx = DW'(in_end_x) - DW'(in_start_x);
    assign dy = DW'(in_end_y) - DW'(in_start_y);
    assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign x_major = (ax >= ay);

    always_comb
    begin
        flags_next.op         = in_op;
        flags_next.x_negative = dx[DW-1];
        flags_next.y_negative = dy[DW-1];
        flags_next.x_is_major = x_major;
    end

    assign in_ready = !valid_reg || cmd_ready;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            flags_reg <= flags_next;
            sx_reg    <= in_start_x;
            sy_reg    <= in_start_y;
            major_reg <= x_major ? ax : ay;
            minor_reg <= x_major ? ay : ax;
        end
    end

    assign cmd_valid   = valid_reg;
    assign cmd_flags   = flags_reg;
    assign cmd_start_x = sx_reg;
    assign cmd_start_y = sy_reg;
    assign cmd_major   = major_reg;
    assign cmd_minor   = minor_reg;

endmodule

### hdl/blsp_queue.sv
// ----------------------------------------------------------------------------
// blsp_queue
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module blsp_queue #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/blsp_back.sv
// ----------------------------------------------------------------------------
// blsp_back
// Holds the running line and steps it once per advance command while active;
// results sit in an output register, and a downstream stall holds off commands.
// ----------------------------------------------------------------------------
module blsp_back
    import blsp_pkg::*;
#(
    parameter int COORD_BITS = 11
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  blsp_cmd_flags_t       cmd_flags,
    input  logic [COORD_BITS-1:0] cmd_start_x,
    input  logic [COORD_BITS-1:0] cmd_start_y,
    input  logic [COORD_BITS:0]   cmd_major,
    input  logic [COORD_BITS:0]   cmd_minor,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS-1:0] out_y,
    output logic                  out_last
);

    localparam int DW = COORD_BITS + 1;

    logic [COORD_BITS-1:0] cur_x_reg;
    logic [COORD_BITS-1:0] cur_y_reg;
    logic [DW-1:0]         error_acc_reg;
    logic [DW-1:0]         major_delta_reg;
    logic [DW-1:0]         minor_delta_reg;
    logic [DW-1:0]         steps_left_reg;
    logic                  x_negative_reg;
    logic                  y_negative_reg;
    logic                  x_is_major_reg;
    logic                  line_active_reg;
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic                  out_last_reg;

    logic                  pop;
    logic                  do_load;
    logic                  do_step;
    logic [DW-1:0]         err_sum;
    logic                  minor_step;
    logic [DW-1:0]         err_next;
    logic [COORD_BITS-1:0] x_moved;
    logic [COORD_BITS-1:0] y_moved;
    logic                  step_x;
    logic                  step_y;
    logic [COORD_BITS-1:0] x_next;
    logic [COORD_BITS-1:0] y_next;
    logic                  last_next;

    assign cmd_ready = !out_valid_reg || out_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign do_load   = pop && (cmd_flags.op == OP_LOAD);
    assign do_step   = pop && (cmd_flags.op == OP_ADVANCE) && line_active_reg;

    assign err_sum    = error_acc_reg + minor_delta_reg;
    assign minor_step = (err_sum >= major_delta_reg);
    assign err_next   = minor_step ? err_sum - major_delta_reg : err_sum;

    assign x_moved = cur_x_reg + (x_negative_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
    assign y_moved = cur_y_reg + (y_negative_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
    assign step_x  = x_is_major_reg || minor_step;
    assign step_y  = !x_is_major_reg || minor_step;
    assign x_next  = step_x ? x_moved : cur_x_reg;
    assign y_next  = step_y ? y_moved : cur_y_reg;
    assign last_next = (steps_left_reg == DW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            error_acc_reg   <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            steps_left_reg  <= '0;
            x_negative_reg  <= 1'b0;
            y_negative_reg  <= 1'b0;
            x_is_major_reg  <= 1'b1;
            line_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (do_load)
            begin
                cur_x_reg       <= cmd_start_x;
                cur_y_reg       <= cmd_start_y;
                error_acc_reg   <= '0;
                major_delta_reg <= cmd_major;
                minor_delta_reg <= cmd_minor;
                steps_left_reg  <= cmd_major;
                x_negative_reg  <= cmd_flags.x_negative;
                y_negative_reg  <= cmd_flags.y_negative;
                x_is_major_reg  <= cmd_flags.x_is_major;
                line_active_reg <= (cmd_major != '0);
            end
            else if (do_step)
            begin
                cur_x_reg       <= x_next;
                cur_y_reg       <= y_next;
                error_acc_reg   <= err_next;
                steps_left_reg  <= steps_left_reg - 1'b1;
                line_active_reg <= !last_next;
            end

            if (do_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            out_x_reg    <= x_next;
            out_y_reg    <= y_next;
            out_last_reg <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

endmodule

### tb/tb_bresenham_line_stepper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_stepper_top
// Self-checking bench for the line stepper. Loads lines and requests points
// with random gaps on both streams. A scoreboard steps its own copy of the
// rasterizer for every accepted word and compares each point in order.
// ----------------------------------------------------------------------------
module tb_bresenham_line_stepper_top;
    import blsp_pkg::*;

    localparam int CB      = 11;
    localparam int IN_W    = ((4*CB+7)/8)*8;
    localparam int OUT_W   = ((2*CB+7)/8)*8;
    localparam int C_MIN   = -(1 << (CB-1));
    localparam int C_MAX   = (1 << (CB-1)) - 1;
    localparam int N_ITEMS = 1800;

    typedef logic signed [CB-1:0] coord_t;

    class point_scoreboard;
        typedef struct packed {
            logic [CB-1:0] x;
            logic [CB-1:0] y;
            logic          last;
        } point_t;

        logic [CB-1:0] pos_x, pos_y;
        logic [CB:0]   err_acc, major_d, minor_d, steps_left;
        bit            neg_x, neg_y, x_major, active;
        point_t        pending_points[$];
        int            mismatches;

        function new();
            pos_x = '0;
            pos_y = '0;
            err_acc = '0;
            major_d = '0;
            minor_d = '0;
            steps_left = '0;
            neg_x = 0;
            neg_y = 0;
            x_major = 1;
            active = 0;
            mismatches = 0;
        endfunction

        function void note_word(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            int     dx, dy;
            point_t p;
            if (op == OP_LOAD) begin
                dx = int'(ex) - int'(sx);
                dy = int'(ey) - int'(sy);
                neg_x = dx < 0;
                neg_y = dy < 0;
                if (neg_x) dx = -dx;
                if (neg_y) dy = -dy;
                x_major = dx >= dy;
                major_d = x_major ? dx[CB:0] : dy[CB:0];
                minor_d = x_major ? dy[CB:0] : dx[CB:0];
                pos_x = sx;
                pos_y = sy;
                err_acc = '0;
                steps_left = major_d;
                active = major_d != 0;
                return;
            end
            if (!active)
                return;
            err_acc = err_acc + minor_d;
            if (x_major)
                pos_x = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
            else
                pos_y = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
            if (err_acc >= major_d) begin
                err_acc = err_acc - major_d;
                if (x_major)
                    pos_y = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
                else
                    pos_x = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
            end
            steps_left = steps_left - 1'b1;
            if (steps_left == 0)
                active = 0;
            p.x = pos_x;
            p.y = pos_y;
            p.last = !active;
            pending_points.push_back(p);
        endfunction

        function void check_point(logic [OUT_W-1:0] data, logic last);
            point_t p;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected point x=%0d y=%0d last=%0b",
                             $signed(data[CB-1:0]), $signed(data[2*CB-1:CB]), last);
                return;
            end
            p = pending_points.pop_front();
            if (data[CB-1:0] !== p.x || data[2*CB-1:CB] !== p.y || last !== p.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: point exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                             $signed(p.x), $signed(p.y), p.last,
                             $signed(data[CB-1:0]), $signed(data[2*CB-1:CB]), last);
            end
        endfunction

        function int pending();
            return pending_points.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             s_axis_tuser = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;

    point_scoreboard  points_sb = new();
    int               words_sent = 0;
    int               points_seen = 0;
    bit               tx_fast = 0;
    bit               rx_fast = 0;

    bresenham_line_stepper_top #(.COORD_BITS(CB)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #20_000_000;
        $display("tb_bresenham_line_stepper_top NOT OK");
        $finish;
    end

    function automatic coord_t clamp_coord(int v);
        if (v < C_MIN) return coord_t'(C_MIN);
        if (v > C_MAX) return coord_t'(C_MAX);
        return coord_t'(v);
    endfunction

    function automatic coord_t near_coord(coord_t base, int reach);
        int v;
        v = int'(base) + int'($urandom_range(0, 2*reach)) - reach;
        return clamp_coord(v);
    endfunction

    // one word on s_axis; leaves tvalid high only when the next word follows at once
    task automatic send_word(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_W-4*CB){1'b0}}, ey, ex, sy, sx};
        do @(posedge clk); while (!s_axis_tready);
        points_sb.note_word(op, sx, sy, ex, ey);
        words_sent++;
        gap = tx_fast ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_advances(int n);
        repeat (n)
            send_word(OP_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom));
    endtask

    task automatic run_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, int n);
        send_word(OP_LOAD, sx, sy, ex, ey);
        send_advances(n);
    endtask

    task automatic random_line();
        coord_t sx, sy, ex, ey;
        int     kind, steps, n, r;
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            ex = sx;
            ey = sy;
        end else if (kind < 15) begin
            ex = coord_t'($urandom);
            ey = coord_t'($urandom);
        end else if (kind < 22) begin
            ex = near_coord(sx, 200);
            ey = near_coord(sy, 200);
        end else begin
            ex = near_coord(sx, 20);
            ey = near_coord(sy, 20);
        end
        steps = int'(ex) - int'(sx);
        if (steps < 0) steps = -steps;
        r = int'(ey) - int'(sy);
        if (r < 0) r = -r;
        if (r > steps) steps = r;
        r = $urandom_range(0, 99);
        if (kind >= 5 && kind < 15)
            n = $urandom_range(0, 30);
        else if (r < 70)
            n = steps;
        else if (r < 85)
            n = $urandom_range(0, steps);
        else
            n = steps + $urandom_range(1, 3);
        run_line(sx, sy, ex, ey, n);
    endtask

    // receiver
    initial
    begin
        int gap;
        @(posedge clk iff rst_n);
        forever begin
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            points_sb.check_point(m_axis_tdata, m_axis_tlast);
            points_seen++;
            if ($urandom_range(0, 31) == 0)
                rx_fast = !rx_fast;
            if (points_seen == 400 || points_seen == 1200)
                gap = 80;
            else
                gap = rx_fast ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // sender
    initial
    begin
        bit paused;
        int tail;
        paused = 0;
        @(posedge clk iff rst_n);

        send_advances(1);
        run_line(coord_t'(C_MIN), coord_t'(C_MIN), coord_t'(C_MAX), coord_t'(C_MAX), 3);
        run_line(coord_t'(C_MAX), coord_t'(C_MAX), coord_t'(C_MIN), coord_t'(C_MIN), 2);
        run_line(coord_t'(5), coord_t'(-7), coord_t'(5), coord_t'(-7), 1);
        run_line(coord_t'(1020), coord_t'(0), coord_t'(C_MAX), coord_t'(0), 4);
        run_line(coord_t'(0), coord_t'(-1021), coord_t'(0), coord_t'(C_MIN), 3);
        run_line(coord_t'(-3), coord_t'(2), coord_t'(-4), coord_t'(7), 5);

        while (words_sent < N_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                tx_fast = !tx_fast;
            random_line();
            if (!paused && words_sent >= N_ITEMS/2) begin
                paused = 1;
                s_axis_tvalid <= 1'b0;
                do @(posedge clk); while (points_sb.pending() != 0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (points_sb.pending() != 0) @(posedge clk);
        tail = 20;
        repeat (tail) @(posedge clk);
        if (points_sb.mismatches == 0)
            $display("tb_bresenham_line_stepper_top OK");
        else
            $display("tb_bresenham_line_stepper_top NOT OK");
        $finish;
    end

endmodule
